// ===== design/grp_pkg.sv =====
`default_nettype none

package grp_pkg;

  // free list geometry
  localparam int MAX_FREE = 64;
  localparam int IDX_W    = $clog2(MAX_FREE);
  localparam int CNT_W    = $clog2(MAX_FREE + 1);

  // rectangle geometry
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = 13;
  localparam int POS_W    = 12;
  localparam int AREA_W   = 2 * SIDE_W;
  localparam int KEY_W    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIDE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 1'd1;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_PLACE = 1'b1;

  typedef enum logic [1:0] {
    ST_PLACED   = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_CALC,
    S_AREA,
    S_DEC,
    S_MOVE,
    S_PUSH0,
    S_PUSH1,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [SIDE_W-1:0] size_x;
    logic [SIDE_W-1:0] size_y;
  } free_entry_t;

endpackage

`default_nettype wire

// ===== design/grp_in_if.sv =====
`default_nettype none

interface grp_in_if;
  import grp_pkg::*;

  logic                valid;
  logic                ready;
  logic                command;
  logic [SIDE_W-1:0]   rect_width;
  logic [SIDE_W-1:0]   rect_height;
  logic [KEY_W-1:0]    key;

  modport source (output valid, output command, output rect_width, output rect_height,
                  output key, input ready);
  modport sink   (input valid, input command, input rect_width, input rect_height,
                  input key, output ready);
endinterface

`default_nettype wire

// ===== design/grp_out_if.sv =====
`default_nettype none

interface grp_out_if;
  import grp_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    out_key;
  logic [POS_W-1:0]    pos_x;
  logic [POS_W-1:0]    pos_y;
  logic [1:0]          status;

  modport source (output valid, output out_key, output pos_x, output pos_y, output status,
                  input ready);
  modport sink   (input valid, input out_key, input pos_x, input pos_y, input status,
                  output ready);
endinterface

`default_nettype wire

// ===== design/guillotine_rect_packer_top.sv =====
// Flow: a clear word, or a place word on an empty list, goes from S_IDLE straight to S_RESP.
//   A place word scans 1..MAX_FREE free entries backward in S_SRCH, reading one per cycle,
//   and goes to S_RESP when nothing fits; a fit passes S_CALC, S_AREA and S_DEC, then on
//   overflow S_RESP, else S_MOVE (hit not last) and S_PUSH0/S_PUSH1 per split, as needed.
// Throughput: one word at a time; the next word is taken the cycle after the result is
//   registered. Results may wait at the output.
// Reset (synchronous, rst_n low): free count zero, bin size 4096 x 4096, output empty.
`default_nettype none

module guillotine_rect_packer_top (
  input  wire                          clk,
  input  wire                          rst_n,
  grp_in_if.sink                       in_ch,
  grp_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [grp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [grp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import grp_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [SIDE_W-1:0]  bin_w_r, bin_h_r;

  free_entry_t        mem [MAX_FREE];
  free_entry_t        rdata_r;
  logic [IDX_W-1:0]   raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   waddr;
  free_entry_t        wdata;

  logic [IDX_W-1:0]   chk_idx_r;
  logic               first_r;
  free_entry_t        last_r;
  free_entry_t        hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [SIDE_W-1:0]  rw_r, rh_r;
  logic [KEY_W-1:0]   key_r;

  logic [POS_W-1:0]   rx_r, by_r;
  logic [SIDE_W-1:0]  rsz_w_r, bsz_h_r;
  logic [AREA_W-1:0]  r_area_r, b_area_r;

  free_entry_t        p0_r, p1_r;
  logic [1:0]         np_r;
  logic [IDX_W-1:0]   wptr_r;

  status_t            res_status_r;
  logic [POS_W-1:0]   res_x_r, res_y_r;

  logic               out_valid_r;
  logic [KEY_W-1:0]   out_key_r;
  logic [POS_W-1:0]   out_x_r, out_y_r;
  status_t            out_status_r;

  logic               in_ready;
  logic               accept;
  logic               load_out;
  logic               fit;
  logic [SIDE_W-1:0]  clamp_w, clamp_h;
  logic [CNT_W-1:0]   n_cnt;
  logic [1:0]         pushes;
  logic [CNT_W:0]     total;
  logic               ovf;
  logic               r_first, r_nz, b_nz;
  free_entry_t        r_ent, b_ent;

  assign accept  = in_ch.valid && in_ready;
  assign fit     = (rdata_r.size_x >= rw_r) && (rdata_r.size_y >= rh_r);
  assign clamp_w = (bin_w_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : bin_w_r;
  assign clamp_h = (bin_h_r > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : bin_h_r;

  // split bookkeeping, valid in S_DEC
  assign n_cnt   = count_r - CNT_W'(1);
  assign r_nz    = (r_area_r != '0);
  assign b_nz    = (b_area_r != '0);
  assign pushes  = {1'b0, r_nz} + {1'b0, b_nz};
  assign total   = (CNT_W+1)'(n_cnt) + (CNT_W+1)'(pushes);
  assign ovf     = total > (CNT_W+1)'(MAX_FREE);
  assign r_first = r_area_r > b_area_r;
  assign r_ent   = '{pos_x: rx_r, pos_y: hit_r.pos_y, size_x: rsz_w_r, size_y: rh_r};
  assign b_ent   = '{pos_x: hit_r.pos_x, pos_y: by_r, size_x: hit_r.size_x, size_y: bsz_h_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_PLACE && count_r != '0) state_nxt = S_SRCH;
          else state_nxt = S_RESP;
        end
      end
      S_SRCH: begin
        if (fit) state_nxt = S_CALC;
        else if (chk_idx_r == '0) state_nxt = S_RESP;
      end
      S_CALC: state_nxt = S_AREA;
      S_AREA: state_nxt = S_DEC;
      S_DEC: begin
        if (ovf) state_nxt = S_RESP;
        else if (hit_idx_r != n_cnt[IDX_W-1:0]) state_nxt = S_MOVE;
        else if (pushes != 2'd0) state_nxt = S_PUSH0;
        else state_nxt = S_RESP;
      end
      S_MOVE:  state_nxt = (np_r != 2'd0) ? S_PUSH0 : S_RESP;
      S_PUSH0: state_nxt = (np_r == 2'd2) ? S_PUSH1 : S_RESP;
      S_PUSH1: state_nxt = S_RESP;
      S_RESP: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    mem_we   = 1'b0;
    waddr    = '0;
    wdata    = '{pos_x: '0, pos_y: '0, size_x: clamp_w, size_y: clamp_h};
    raddr    = IDX_W'(count_r - CNT_W'(1));
    case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        mem_we   = accept && (in_ch.command == CMD_CLEAR);
      end
      S_SRCH: raddr = chk_idx_r - IDX_W'(1);
      S_MOVE: begin
        mem_we = 1'b1;
        waddr  = hit_idx_r;
        wdata  = last_r;
      end
      S_PUSH0: begin
        mem_we = 1'b1;
        waddr  = wptr_r;
        wdata  = p0_r;
      end
      S_PUSH1: begin
        mem_we = 1'b1;
        waddr  = IDX_W'(wptr_r + IDX_W'(1));
        wdata  = p1_r;
      end
      S_RESP: load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // free list memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      bin_w_r     <= SIDE_W'(MAX_SIDE);
      bin_h_r     <= SIDE_W'(MAX_SIDE);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIN_WIDTH:  bin_w_r <= cfg_data;
          CFG_BIN_HEIGHT: bin_h_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_IDLE && accept && in_ch.command == CMD_CLEAR) count_r <= CNT_W'(1);
      if (state_r == S_DEC && !ovf) count_r <= total[CNT_W-1:0];
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rw_r      <= in_ch.rect_width;
          rh_r      <= in_ch.rect_height;
          key_r     <= in_ch.key;
          chk_idx_r <= raddr;
          first_r   <= 1'b1;
          res_x_r   <= '0;
          res_y_r   <= '0;
          res_status_r <= (in_ch.command == CMD_CLEAR) ? ST_CLEARED : ST_NOFIT;
        end
      end
      S_SRCH: begin
        // first entry scanned is the last one of the list
        if (first_r) last_r <= rdata_r;
        first_r <= 1'b0;
        if (fit) begin
          hit_r     <= rdata_r;
          hit_idx_r <= chk_idx_r;
        end else begin
          chk_idx_r <= chk_idx_r - IDX_W'(1);
        end
      end
      S_CALC: begin
        rx_r    <= POS_W'(hit_r.pos_x + rw_r[POS_W-1:0]);
        by_r    <= POS_W'(hit_r.pos_y + rh_r[POS_W-1:0]);
        rsz_w_r <= hit_r.size_x - rw_r;
        bsz_h_r <= hit_r.size_y - rh_r;
      end
      S_AREA: begin
        r_area_r <= AREA_W'(rsz_w_r) * AREA_W'(rh_r);
        b_area_r <= AREA_W'(hit_r.size_x) * AREA_W'(bsz_h_r);
      end
      S_DEC: begin
        wptr_r <= n_cnt[IDX_W-1:0];
        np_r   <= pushes;
        if (r_first) begin
          p0_r <= r_ent;
          p1_r <= b_ent;
        end else begin
          p0_r <= b_nz ? b_ent : r_ent;
          p1_r <= r_ent;
        end
        if (ovf) begin
          res_status_r <= ST_OVERFLOW;
        end else begin
          res_status_r <= ST_PLACED;
          res_x_r      <= hit_r.pos_x;
          res_y_r      <= hit_r.pos_y;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_key_r    <= key_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_status_r <= res_status_r;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_key = out_key_r;
  assign out_ch.pos_x   = out_x_r;
  assign out_ch.pos_y   = out_y_r;
  assign out_ch.status  = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_FREE))
    else $error("free count above capacity");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> CNT_W'(chk_idx_r) < count_r)
    else $error("scan index outside free list");

  a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOVE |-> CNT_W'(hit_idx_r) < count_r - CNT_W'(np_r))
    else $error("move targets the last entry");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.command == CMD_CLEAR) |=> count_r == CNT_W'(1))
    else $error("clear did not reset free count");
`endif

endmodule

`default_nettype wire

// ===== dv/guillotine_rect_packer_top_test.sv =====
`default_nettype none

module guillotine_rect_packer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import grp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int SEG_WORDS   = 222;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    status_t          st;
  } placement_t;

  typedef enum logic {ROW_WORD, ROW_BIN} row_kind_t;

  // ROW_BIN rows reuse w/h as the bin size; reps > 1 steps the height by one per word
  typedef struct packed {
    row_kind_t         kind;
    logic              cmd;
    logic [SIDE_W-1:0] w;
    logic [SIDE_W-1:0] h;
    logic [KEY_W-1:0]  key;
    logic [7:0]        reps;
    logic              typed;
    logic [POS_W-1:0]  ex;
    logic [POS_W-1:0]  ey;
    status_t           est;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic sink_ready = 1'b0;

  grp_in_if  in_ch ();
  grp_out_if out_ch ();

  assign out_ch.ready = sink_ready;

  guillotine_rect_packer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the packer state
  free_entry_t       free_list [MAX_FREE];
  logic [CNT_W-1:0]  free_cnt;
  logic [SIDE_W-1:0] bin_w;
  logic [SIDE_W-1:0] bin_h;

  placement_t placements_due [$];
  int mismatches;
  int words_sent;
  int stall_cycles;
  int feed_idle_pct;
  int drain_idle_pct;

  function automatic placement_t next_placement(input logic cmd, input logic [SIDE_W-1:0] rw,
                                                input logic [SIDE_W-1:0] rh,
                                                input logic [KEY_W-1:0] key);
    placement_t res;
    int slot;
    int n;
    int pushes;
    bit hit;
    free_entry_t sp;
    free_entry_t rs;
    free_entry_t bs;
    longint unsigned r_area;
    longint unsigned b_area;
    res.key = key;
    res.x   = '0;
    res.y   = '0;
    hit     = 1'b0;
    if (cmd == CMD_CLEAR) begin
      free_list[0].pos_x  = '0;
      free_list[0].pos_y  = '0;
      free_list[0].size_x = (bin_w > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : bin_w;
      free_list[0].size_y = (bin_h > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : bin_h;
      free_cnt = CNT_W'(1);
      res.st = ST_CLEARED;
    end else begin
      // newest entries first
      slot = int'(free_cnt);
      while (slot > 0 && !hit) begin
        slot--;
        if (free_list[slot].size_x >= rw && free_list[slot].size_y >= rh) hit = 1'b1;
      end
      if (!hit) begin
        res.st = ST_NOFIT;
      end else begin
        sp = free_list[slot];
        rs.pos_x  = POS_W'(sp.pos_x + rw);
        rs.pos_y  = sp.pos_y;
        rs.size_x = sp.size_x - rw;
        rs.size_y = rh;
        bs.pos_x  = sp.pos_x;
        bs.pos_y  = POS_W'(sp.pos_y + rh);
        bs.size_x = sp.size_x;
        bs.size_y = sp.size_y - rh;
        r_area = 64'(rs.size_x) * 64'(rs.size_y);
        b_area = 64'(bs.size_x) * 64'(bs.size_y);
        pushes = int'(r_area != 0) + int'(b_area != 0);
        n = int'(free_cnt) - 1;
        if (n + pushes > MAX_FREE) begin
          res.st = ST_OVERFLOW;
        end else begin
          res.x  = sp.pos_x;
          res.y  = sp.pos_y;
          res.st = ST_PLACED;
          if (slot != n) free_list[slot] = free_list[n];
          // larger split first, bottom wins a tie
          if (r_area > b_area) begin
            if (r_area != 0) begin free_list[n] = rs; n++; end
            if (b_area != 0) begin free_list[n] = bs; n++; end
          end else begin
            if (b_area != 0) begin free_list[n] = bs; n++; end
            if (r_area != 0) begin free_list[n] = rs; n++; end
          end
          free_cnt = CNT_W'(n);
        end
      end
    end
    return res;
  endfunction

  task report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) sink_ready <= ($urandom_range(99) >= drain_idle_pct);

  always @(posedge clk) begin
    placement_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (placements_due.size() == 0) begin
        report_mismatch($sformatf("result key %h with nothing pending", out_ch.out_key));
      end else begin
        want = placements_due.pop_front();
        if (out_ch.out_key !== want.key)
          report_mismatch($sformatf("out_key got %h want %h", out_ch.out_key, want.key));
        if (out_ch.pos_x !== want.x)
          report_mismatch($sformatf("key %h pos_x got %0d want %0d", want.key,
                                    out_ch.pos_x, want.x));
        if (out_ch.pos_y !== want.y)
          report_mismatch($sformatf("key %h pos_y got %0d want %0d", want.key,
                                    out_ch.pos_y, want.y));
        if (out_ch.status !== want.st)
          report_mismatch($sformatf("key %h status got %0d want %0d", want.key,
                                    out_ch.status, want.st));
      end
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("guillotine_rect_packer_top_test NOT OK");
      $finish;
    end
  end

  // valid stays up when the next word follows without a gap
  task automatic send_word(input logic cmd, input logic [SIDE_W-1:0] w,
                           input logic [SIDE_W-1:0] h, input logic [KEY_W-1:0] key,
                           input logic typed = 1'b0, input placement_t typed_res = '0);
    placement_t got;
    while ($urandom_range(99) < feed_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.rect_width  <= w;
    in_ch.rect_height <= h;
    in_ch.key         <= key;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    got = next_placement(cmd, w, h, key);
    placements_due.insert(placements_due.size(), typed ? typed_res : got);
    words_sent++;
  endtask

  task automatic set_bin(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    in_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BIN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    bin_w = w;
    cfg_index <= CFG_BIN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    bin_h = h;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SIDE_W-1:0] random_side(input int dim);
    int d;
    d = (dim > MAX_SIDE) ? MAX_SIDE : dim;
    case ($urandom_range(9))
      0: return '0;
      1: return SIDE_W'($urandom_range(8191));
      2: return SIDE_W'(d);
      3: return SIDE_W'(d + 1);
      4: return SIDE_W'($urandom_range((d > 1) ? d : 1, 1));
      default: return SIDE_W'($urandom_range((d / 8 > 1) ? d / 8 : 1, 1));
    endcase
  endfunction

  task automatic run_episode();
    int kind;
    int len;
    int base;
    kind = $urandom_range(9);
    if (kind != 9)
      send_word(CMD_CLEAR, SIDE_W'($urandom), SIDE_W'($urandom), KEY_W'($urandom));
    if (kind < 2) begin
      // rising heights: every word splits the tall bottom space, list grows to overflow
      base = $urandom_range(3, 1);
      for (int k = 0; k < 66; k++)
        send_word(CMD_PLACE, SIDE_W'($urandom_range(8, 1)), SIDE_W'(base + k),
                  KEY_W'($urandom));
    end else if (kind < 9) begin
      len = $urandom_range(40, 1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0)
          send_word(CMD_CLEAR, SIDE_W'($urandom), SIDE_W'($urandom), KEY_W'($urandom));
        else
          send_word(CMD_PLACE, random_side(bin_w), random_side(bin_h), KEY_W'($urandom));
      end
    end else begin
      len = $urandom_range(8, 1);
      for (int k = 0; k < len; k++)
        send_word(CMD_PLACE, SIDE_W'($urandom), SIDE_W'($urandom), KEY_W'($urandom));
    end
  endtask

  initial begin
    row_t plan [28];
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    int goal;

    plan = '{
      '{ROW_WORD, CMD_PLACE, 13'd5,    13'd5,    16'h0001, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_CLEAR, 13'd0,    13'd0,    16'hFFFF, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd4096, 13'd4096, 16'h0000, 8'd1,  1'b1, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd0,    13'd0,    16'h8000, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_CLEAR, 13'd8191, 13'd8191, 16'h0002, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd8191, 13'd1,    16'h0003, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd8191, 16'h0004, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_PLACE, 13'd4097, 13'd4096, 16'h0005, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_PLACE, 13'd0,    13'd0,    16'h0006, 8'd1,  1'b1, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd1,    16'h0007, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd2,    16'h0100, 8'd62, 1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd64,   16'h0200, 8'd1,  1'b1, 12'd0, 12'd0, ST_OVERFLOW},
      '{ROW_WORD, CMD_PLACE, 13'd4096, 13'd2080, 16'h0201, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_BIN,  CMD_CLEAR, 13'd8191, 13'd0,    16'h0000, 8'd0,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_CLEAR, 13'd0,    13'd0,    16'h0300, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd1,    16'h0301, 8'd1,  1'b1, 12'd0, 12'd0, ST_NOFIT},
      '{ROW_WORD, CMD_PLACE, 13'd4096, 13'd0,    16'h0302, 8'd1,  1'b1, 12'd0, 12'd0, ST_PLACED},
      '{ROW_BIN,  CMD_CLEAR, 13'd4,    13'd4,    16'h0000, 8'd0,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_CLEAR, 13'd0,    13'd0,    16'h0400, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd0,    13'd2,    16'h0401, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd1,    16'h0402, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_BIN,  CMD_CLEAR, 13'd1,    13'd8191, 16'h0000, 8'd0,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_CLEAR, 13'd0,    13'd0,    16'h0500, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd1,    13'd4096, 16'h0501, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_BIN,  CMD_CLEAR, 13'd0,    13'd0,    16'h0000, 8'd0,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_CLEAR, 13'd0,    13'd0,    16'h0600, 8'd1,  1'b1, 12'd0, 12'd0, ST_CLEARED},
      '{ROW_WORD, CMD_PLACE, 13'd0,    13'd0,    16'h0601, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED},
      '{ROW_WORD, CMD_PLACE, 13'd0,    13'd0,    16'h0602, 8'd1,  1'b0, 12'd0, 12'd0, ST_PLACED}
    };

    free_cnt       = '0;
    bin_w          = SIDE_W'(4096);
    bin_h          = SIDE_W'(4096);
    mismatches     = 0;
    words_sent     = 0;
    stall_cycles   = 0;
    feed_idle_pct  = 14;
    drain_idle_pct = 47;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_CLEAR;
    in_ch.rect_width  <= '0;
    in_ch.rect_height <= '0;
    in_ch.key         <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_BIN_WIDTH;
    cfg_data          <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_BIN) begin
        set_bin(plan[r].w, plan[r].h);
      end else begin
        for (int k = 0; k < plan[r].reps; k++)
          send_word(plan[r].cmd, plan[r].w, SIDE_W'(plan[r].h + k), plan[r].key, plan[r].typed,
                    placement_t'{plan[r].key, plan[r].ex, plan[r].ey, plan[r].est});
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < 3; seg++) begin
        case (mode * 3 + seg)
          0: begin w = CFG_DATA_W'(4096); h = CFG_DATA_W'(4096); end
          1: begin w = CFG_DATA_W'(8191); h = CFG_DATA_W'(8191); end
          2: begin
            w = CFG_DATA_W'($urandom_range(256, 16));
            h = CFG_DATA_W'($urandom_range(256, 16));
          end
          3: begin w = CFG_DATA_W'(4096); h = CFG_DATA_W'(1); end
          4: begin
            w = CFG_DATA_W'($urandom_range(8191, 1));
            h = CFG_DATA_W'($urandom_range(8191, 1));
          end
          5: begin w = CFG_DATA_W'(1); h = CFG_DATA_W'(4096); end
          6: begin w = CFG_DATA_W'($urandom_range(4096, 2100)); h = CFG_DATA_W'(4096); end
          7: begin w = '0; h = CFG_DATA_W'($urandom_range(4096)); end
          default: begin
            w = CFG_DATA_W'($urandom_range(64, 1));
            h = CFG_DATA_W'($urandom_range(64, 1));
          end
        endcase
        set_bin(w, h);
        case (mode)
          0: begin feed_idle_pct = 14; drain_idle_pct = 47; end
          1: begin feed_idle_pct = 47; drain_idle_pct = 14; end
          default: begin feed_idle_pct = 0; drain_idle_pct = 0; end
        endcase
        goal = words_sent + SEG_WORDS;
        while (words_sent < goal) run_episode();
      end
    end

    in_ch.valid <= 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("guillotine_rect_packer_top_test OK");
    else
      $display("guillotine_rect_packer_top_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/grp_pkg.sv
design/grp_in_if.sv
design/grp_out_if.sv
design/guillotine_rect_packer_top.sv
dv/guillotine_rect_packer_top_test.sv
